// ===== src/fdfb_pkg.sv =====
// fdfb_pkg: shared types, constants and helper functions of the footer builder
// no dependencies
`default_nettype none
package fdfb_pkg;

  localparam int unsigned NUM_WORDS = 64;
  localparam int unsigned IDX_W     = $clog2(NUM_WORDS);
  localparam int unsigned TS_W      = 28;
  localparam int unsigned SUM_STEPS = 10;

  localparam logic [TS_W-1:0] SECT_MAX_ALL = TS_W'(65535 * 16 * 255);
  localparam logic [TS_W-1:0] SECT_MAX_63  = TS_W'(65535 * 16 * 63);

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam logic [31:0] HASH_INIT2 = 32'hDEADBEEF;
  localparam logic [31:0] HASH_INIT3 = 32'hCAFEBABE;

  localparam logic [63:0] FOOTER_COOKIE = 64'h636F6E6563746978;
  localparam logic [31:0] FEATURES      = 32'h00000002;
  localparam logic [31:0] FMT_VERSION   = 32'h00010000;
  localparam logic [63:0] DATA_OFFSET   = 64'hFFFFFFFFFFFFFFFF;
  localparam logic [31:0] CREATOR_APP   = 32'h62736369;
  localparam logic [31:0] CREATOR_VER   = 32'h00010000;
  localparam logic [31:0] CREATOR_HOST  = 32'h5769326B;
  localparam logic [31:0] DISK_TYPE     = 32'h00000002;

  localparam logic [7:0] SPT_17  = 8'd17;
  localparam logic [7:0] SPT_31  = 8'd31;
  localparam logic [7:0] SPT_63  = 8'd63;
  localparam logic [7:0] SPT_255 = 8'd255;

  // reciprocals ceil(2^shift / spt), exact for every sector count below 2^28
  localparam logic [28:0] RECIP_17  = 29'd505290271;
  localparam logic [28:0] RECIP_31  = 29'd277094665;
  localparam logic [28:0] RECIP_63  = 29'd272696337;
  localparam logic [28:0] RECIP_255 = 29'd269488145;
  localparam int unsigned SHIFT_17  = 33;
  localparam int unsigned SHIFT_31  = 33;
  localparam int unsigned SHIFT_63  = 34;
  localparam int unsigned SHIFT_255 = 36;

  localparam logic [3:0][3:0] HASH_OFFS = {4'd11, 4'd7, 4'd3, 4'd0};

  typedef struct packed {
    logic [63:0]      disk_bytes;
    logic [31:0]      stamp;
    logic [31:0]      geom;
    logic [31:0]      chksum;
    logic [3:0][31:0] hash;
  } footer_t;

  typedef enum logic [1:0] {F_IDLE, F_WORK, F_SUM, F_PUSH} front_state_t;
  typedef enum logic {GP_SPT, GP_CYL} geo_phase_t;

  function automatic logic [9:0] byte_sum32(input logic [31:0] w);
    byte_sum32 = 10'(w[31:24]) + 10'(w[23:16]) + 10'(w[15:8]) + 10'(w[7:0]);
  endfunction

  function automatic logic [31:0] byte_sum64(input logic [63:0] w);
    byte_sum64 = 32'(byte_sum32(w[63:32])) + 32'(byte_sum32(w[31:0]));
  endfunction

  // byte sum of all fixed footer fields
  localparam logic [31:0] CONST_SUM = byte_sum64(FOOTER_COOKIE)
    + byte_sum64({FEATURES, FMT_VERSION}) + byte_sum64(DATA_OFFSET)
    + byte_sum64({32'h0, CREATOR_APP}) + byte_sum64({CREATOR_VER, CREATOR_HOST})
    + byte_sum64({32'h0, DISK_TYPE});

endpackage
`default_nettype wire

// ===== src/fixed_disk_footer_builder_unit.sv =====
// fixed_disk_footer_builder_unit: top level of the disk image footer builder
// depends on fdfb_pkg, fdfb_front and fdfb_back
// the first word follows the front's work: one to three reciprocal sector multiplies,
//   a 28-step cylinder division and the checksum, then the queue and the back when idle
// the front takes a new request once its footer is in the queue, while the back still sends
// reset is synchronous; it empties the queue and returns both halves to idle
`default_nettype none
module fixed_disk_footer_builder_unit
  import fdfb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [63:0]      disk_bytes,
  input  wire logic [31:0]      stamp,
  input  wire logic [7:0]       unit_id,
  output logic                  strobe,
  output logic [IDX_W-1:0]      word_index,
  output logic [63:0]           word_data,
  output logic                  last_word
);
  // transfer from the front into the one-entry queue
  logic    push_valid, push_ready;
  footer_t push_data;

  // front: hashes, geometry and checksum
  fdfb_front u_front (
    .clk(clk), .rst(rst), .start(start), .disk_bytes(disk_bytes),
    .stamp(stamp), .unit_id(unit_id), .busy(busy),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  // back: queue entry and word sequencer, 64 words then an idle gap before the next footer
  fdfb_back u_back (
    .clk(clk), .rst(rst), .push_valid(push_valid), .push_ready(push_ready),
    .push_data(push_data), .strobe(strobe), .word_index(word_index),
    .word_data(word_data), .last_word(last_word)
  );
endmodule
`default_nettype wire

// ===== src/fdfb_div.sv =====
// fdfb_div: restoring divider, one quotient bit per cycle
// depends on fdfb_pkg
`default_nettype none
module fdfb_div
  import fdfb_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire logic [TS_W-1:0] dividend,
  input  wire logic [7:0]      divisor,
  output logic                 done,
  output logic [TS_W-1:0]      quotient
);
  localparam int unsigned CNT_W = $clog2(TS_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       rem;
  logic [7:0]       dv;
  logic [8:0]       trial;

  assign trial = {rem, quotient[TS_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run      <= 1'b1;
        cnt      <= CNT_W'(TS_W);
        quotient <= dividend;
        rem      <= '0;
        dv       <= divisor;
      end else if (run) begin
        if (trial >= {1'b0, dv}) begin
          rem      <= 8'(trial - {1'b0, dv});
          quotient <= {quotient[TS_W-2:0], 1'b1};
        end else begin
          rem      <= trial[7:0];
          quotient <= {quotient[TS_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/fdfb_front.sv =====
// fdfb_front: takes a request, runs the identifier hashes, geometry and checksum
// depends on fdfb_pkg and fdfb_div
`default_nettype none
module fdfb_front
  import fdfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] disk_bytes,
  input  wire logic [31:0] stamp,
  input  wire logic [7:0]  unit_id,
  output logic             busy,
  output logic             push_valid,
  input  wire logic        push_ready,
  output footer_t          push_data
);
  front_state_t     state, state_next;
  geo_phase_t       gphase;
  logic [127:0]     seed;
  logic [3:0][31:0] h;
  logic [3:0]       rnd;
  logic             hash_done, geo_done;
  logic [TS_W-1:0]  ts;
  logic [7:0]       spt;
  logic [4:0]       heads;
  logic [15:0]      cyl;
  logic [31:0]      sum;
  logic [3:0]       step;
  logic             div_go, div_done;
  logic [TS_W-1:0]  div_a, div_q;
  logic [7:0]       div_b;
  logic [54:0]      sect;
  logic [TS_W-1:0]  ts_in;
  logic [18:0]      heads_c;
  logic [31:0]      grp;
  logic [63:0]      req_bytes;
  logic [31:0]      req_stamp;
  logic             mul_go, mul_done;
  logic [56:0]      prod;
  logic [28:0]      recip;
  logic [TS_W-1:0]  cth;

  fdfb_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  assign sect    = disk_bytes[63:9];
  assign ts_in   = (sect > 55'(SECT_MAX_ALL)) ? SECT_MAX_ALL : sect[TS_W-1:0];
  assign heads_c = 19'((29'(cth) + 29'd1023) >> 10);

  // sector count divided by sectors per track, by reciprocal multiply and shift
  always_comb begin
    unique case (spt)
      SPT_17: begin
        recip = RECIP_17;
        cth   = TS_W'(prod >> SHIFT_17);
      end
      SPT_31: begin
        recip = RECIP_31;
        cth   = TS_W'(prod >> SHIFT_31);
      end
      SPT_63: begin
        recip = RECIP_63;
        cth   = TS_W'(prod >> SHIFT_63);
      end
      default: begin
        recip = RECIP_255;
        cth   = TS_W'(prod >> SHIFT_255);
      end
    endcase
  end

  always_comb begin
    unique case (step)
      4'd0:    grp = push_data.stamp;
      4'd1:    grp = push_data.disk_bytes[63:32];
      4'd2:    grp = push_data.disk_bytes[31:0];
      4'd3:    grp = push_data.disk_bytes[63:32];
      4'd4:    grp = push_data.disk_bytes[31:0];
      4'd5:    grp = push_data.geom;
      4'd6:    grp = h[0];
      4'd7:    grp = h[1];
      4'd8:    grp = h[2];
      4'd9:    grp = h[3];
      default: grp = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (start) state_next = F_WORK;
      F_WORK: if (hash_done && geo_done) state_next = F_SUM;
      F_SUM:  if (step == 4'(SUM_STEPS - 1)) state_next = F_PUSH;
      F_PUSH: if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != F_IDLE);
    push_valid = (state == F_PUSH);
  end

  assign push_data = {req_bytes, req_stamp, {cyl, 3'b000, heads, spt}, ~sum, h};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_go    <= 1'b0;
      mul_go    <= 1'b0;
      mul_done  <= 1'b0;
      hash_done <= 1'b0;
      geo_done  <= 1'b0;
    end else begin
      div_go   <= 1'b0;
      mul_go   <= 1'b0;
      mul_done <= mul_go;
      if (mul_go) prod <= 57'(ts) * 57'(recip);
      unique case (state)
        F_IDLE: if (start) begin
          req_bytes <= disk_bytes;
          req_stamp <= stamp;
          seed      <= {stamp, unit_id, disk_bytes, 24'h0};
          h         <= {HASH_INIT3, HASH_INIT2, FNV_PRIME, FNV_BASIS};
          rnd       <= '0;
          hash_done <= 1'b0;
          geo_done  <= 1'b0;
          ts        <= ts_in;
          gphase    <= GP_SPT;
          sum       <= CONST_SUM;
          step      <= '0;
          mul_go    <= 1'b1;
          if (ts_in >= SECT_MAX_63) begin
            spt   <= SPT_255;
            heads <= 5'd16;
          end else begin
            spt   <= SPT_17;
          end
        end
        F_WORK: begin
          if (!hash_done) begin
            for (int k = 0; k < 4; k++) begin
              h[k] <= 32'((h[k] ^ 32'(seed[8*(15 - 4'(rnd + HASH_OFFS[k])) +: 8]))
                          * FNV_PRIME);
            end
            rnd <= rnd + 1'b1;
            if (rnd == 4'd15) hash_done <= 1'b1;
          end
          unique case (gphase)
            GP_SPT: if (mul_done) begin
              // retry with a larger sectors-per-track when cylinders overflow
              if (spt == SPT_17 && (heads_c > 19'd16 || ({1'b0, cth} >=
                  {heads_c < 19'd4 ? 19'd4 : heads_c, 10'b0}))) begin
                spt    <= SPT_31;
                heads  <= 5'd16;
                mul_go <= 1'b1;
              end else if (spt == SPT_31 && cth >= TS_W'(16384)) begin
                spt    <= SPT_63;
                mul_go <= 1'b1;
              end else begin
                if (spt == SPT_17) begin
                  heads <= (heads_c < 19'd4) ? 5'd4 : heads_c[4:0];
                  div_b <= (heads_c < 19'd4) ? 8'd4 : 8'(heads_c[4:0]);
                end else begin
                  div_b <= 8'd16;
                end
                gphase <= GP_CYL;
                div_go <= 1'b1;
                div_a  <= cth;
              end
            end
            GP_CYL: if (div_done) begin
              cyl      <= (div_q > TS_W'(65535)) ? 16'hFFFF : div_q[15:0];
              geo_done <= 1'b1;
            end
            default: ;
          endcase
        end
        F_SUM: begin
          sum  <= sum + 32'(byte_sum32(grp));
          step <= step + 1'b1;
        end
        F_PUSH: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/fdfb_back.sv =====
// fdfb_back: one-entry queue and the word sequencer that sends the footer
// depends on fdfb_pkg
`default_nettype none
module fdfb_back
  import fdfb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire footer_t          push_data,
  output logic                  strobe,
  output logic [IDX_W-1:0]      word_index,
  output logic [63:0]           word_data,
  output logic                  last_word
);
  logic    slot_valid, active;
  footer_t slot, cur;

  assign push_ready = !slot_valid;
  assign strobe     = active;
  assign last_word  = active && (word_index == IDX_W'(NUM_WORDS - 1));

  always_comb begin
    unique case (word_index)
      IDX_W'(0):  word_data = FOOTER_COOKIE;
      IDX_W'(1):  word_data = {FEATURES, FMT_VERSION};
      IDX_W'(2):  word_data = DATA_OFFSET;
      IDX_W'(3):  word_data = {cur.stamp, CREATOR_APP};
      IDX_W'(4):  word_data = {CREATOR_VER, CREATOR_HOST};
      IDX_W'(5):  word_data = cur.disk_bytes;
      IDX_W'(6):  word_data = cur.disk_bytes;
      IDX_W'(7):  word_data = {cur.geom, DISK_TYPE};
      IDX_W'(8):  word_data = {cur.chksum, cur.hash[0]};
      IDX_W'(9):  word_data = {cur.hash[1], cur.hash[2]};
      IDX_W'(10): word_data = {cur.hash[3], 32'h0};
      default:    word_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      active     <= 1'b0;
      word_index <= '0;
    end else begin
      if (push_valid && push_ready) begin
        slot       <= push_data;
        slot_valid <= 1'b1;
      end
      if (active) begin
        word_index <= word_index + 1'b1;
        if (word_index == IDX_W'(NUM_WORDS - 1)) active <= 1'b0;
      end else if (slot_valid) begin
        cur        <= slot;
        active     <= 1'b1;
        word_index <= '0;
        slot_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench of fixed_disk_footer_builder_unit
// depends on fdfb_pkg and the footer builder rtl; predicts every footer word and checks it
`timescale 1ns / 100ps
`default_nettype none

// holds the footer words still owed by the block and checks each arriving word
class footer_board;
  logic [63:0] owed_data[$];
  logic [5:0]  owed_index[$];
  logic        owed_last[$];
  int          fails;

  function new();
    fails = 0;
  endfunction

  // cylinder/head/sector word, sector count saturated before the divisions
  function automatic logic [31:0] chs_word(logic [63:0] bytes_in);
    logic [63:0] secs;
    logic [31:0] ts, spt, heads, cth, cyl;
    secs = bytes_in >> 9;
    if (secs > 64'(65535 * 16 * 255)) secs = 64'(65535 * 16 * 255);
    ts = secs[31:0];
    if (ts >= 32'(65535 * 16 * 63)) begin
      spt = 255; heads = 16; cth = ts / spt;
    end else begin
      spt = 17;
      cth = ts / spt;
      heads = (cth + 1023) / 1024;
      if (heads < 4) heads = 4;
      if (cth >= heads * 1024 || heads > 16) begin
        spt = 31; heads = 16; cth = ts / spt;
      end
      if (cth >= heads * 1024) begin
        spt = 63; heads = 16; cth = ts / spt;
      end
    end
    cyl = cth / heads;
    if (cyl > 65535) cyl = 65535;
    return {cyl[15:0], heads[7:0], spt[7:0]};
  endfunction

  // a transfer of a request was accepted: queue its 64 words
  function void note_request(logic [63:0] bytes_in, logic [31:0] ts_in, logic [7:0] unit);
    logic [63:0] w[64];
    logic [7:0]  seed[16];
    logic [31:0] h[4];
    logic [31:0] sum;
    int          offs[4];
    offs = '{0, 3, 7, 11};
    for (int i = 0; i < 16; i++) seed[i] = 8'h00;
    for (int i = 0; i < 4; i++) seed[i] = ts_in[31-8*i -: 8];
    seed[4] = unit;
    for (int i = 0; i < 8; i++) seed[5+i] = bytes_in[63-8*i -: 8];
    h = '{fdfb_pkg::FNV_BASIS, fdfb_pkg::FNV_PRIME, fdfb_pkg::HASH_INIT2,
          fdfb_pkg::HASH_INIT3};
    for (int i = 0; i < 16; i++)
      for (int k = 0; k < 4; k++) h[k] = (h[k] ^ 32'(seed[(i + offs[k]) & 15])) * fdfb_pkg::FNV_PRIME;
    for (int i = 0; i < 64; i++) w[i] = 64'h0;
    w[0] = fdfb_pkg::FOOTER_COOKIE;
    w[1] = {fdfb_pkg::FEATURES, fdfb_pkg::FMT_VERSION};
    w[2] = fdfb_pkg::DATA_OFFSET;
    w[3] = {ts_in, fdfb_pkg::CREATOR_APP};
    w[4] = {fdfb_pkg::CREATOR_VER, fdfb_pkg::CREATOR_HOST};
    w[5] = bytes_in;
    w[6] = bytes_in;
    w[7] = {chs_word(bytes_in), fdfb_pkg::DISK_TYPE};
    w[8] = {32'h0, h[0]};
    w[9] = {h[1], h[2]};
    w[10] = {h[3], 32'h0};
    sum = 0;
    for (int i = 0; i < 64; i++)
      for (int b = 0; b < 8; b++) sum += 32'(w[i][8*b +: 8]);
    w[8][63:32] = ~sum;
    for (int i = 0; i < 64; i++) begin
      owed_data.push_back(w[i]);
      owed_index.push_back(6'(i));
      owed_last.push_back(i == 63);
    end
  endfunction

  function void check_word(logic [5:0] idx, logic [63:0] data, logic last);
    logic [63:0] ed;
    logic [5:0]  ei;
    logic        el;
    if (owed_data.size() == 0) begin
      $error("word with nothing owed: word_index %0d", idx);
      fails++;
      return;
    end
    ed = owed_data.pop_front();
    ei = owed_index.pop_front();
    el = owed_last.pop_front();
    if (idx !== ei) begin
      $error("word_index expected %0d actual %0d", ei, idx); fails++;
    end
    if (data !== ed) begin
      $error("word_data expected %h actual %h", ed, data); fails++;
    end
    if (last !== el) begin
      $error("last_word expected %0b actual %0b", el, last); fails++;
    end
  endfunction
endclass

module tb_top;
  import fdfb_pkg::*;

  localparam int STALL_LIMIT = 4000;   // cycles without any transfer

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [63:0]      disk_bytes;
  logic [31:0]      stamp;
  logic [7:0]       unit_id;
  logic             strobe;
  logic [IDX_W-1:0] word_index;
  logic [63:0]      word_data;
  logic             last_word;

  footer_board board;
  int          quiet_cycles;

  fixed_disk_footer_builder_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .disk_bytes(disk_bytes), .stamp(stamp), .unit_id(unit_id),
    .strobe(strobe), .word_index(word_index), .word_data(word_data),
    .last_word(last_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: the block cannot be held off, so every strobed word is checked
  // at the edge; the request transfer is noted at the same edge
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) board.note_request(disk_bytes, stamp, unit_id);
      if (strobe) board.check_word(word_index, word_data, last_word);
      if ((start && !busy) || strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one request transfer: hold start until the block takes it; start stays high
  task automatic send_request(logic [63:0] b, logic [31:0] s, logic [7:0] u);
    start      <= 1'b1;
    disk_bytes <= b;
    stamp      <= s;
    unit_id    <= u;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // disk sizes aimed at each geometry branch and its boundaries
  function automatic logic [63:0] pick_size();
    logic [63:0] secs;
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: secs = 64'($urandom_range(0, 4 * 1024 * 17));
      2: secs = 64'($urandom_range(4 * 1024 * 17, 16 * 1024 * 17));
      3: secs = 64'($urandom_range(16 * 1024 * 17, 16 * 1024 * 63));
      4: secs = 64'($urandom_range(16 * 1024 * 63, 65535 * 16 * 63 + 10));
      5: secs = 64'($urandom_range(65535 * 16 * 63, 65535 * 16 * 255 + 1000));
      6: return 64'($urandom) << $urandom_range(0, 32);
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return (secs << 9) | 64'($urandom_range(0, 511));
  endfunction

  initial begin
    logic [63:0] sizes[$];
    int          burst;
    board      = new();
    rst        = 1'b1;
    start      = 1'b0;
    disk_bytes = '0;
    stamp      = '0;
    unit_id    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and geometry branch boundaries
    sizes = '{64'd0, 64'd511, 64'd512, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
              64'(4*1024*17) << 9, (64'(4*1024*17) << 9) - 1, 64'(16*1024*17) << 9,
              64'(16*1024*31) << 9, 64'(16*1024*63) << 9,
              64'(65535*16*63) << 9, (64'(65535*16*63) << 9) - 512,
              64'(65535*16*255) << 9, (64'(65535*16*255) + 1) << 9,
              64'h0000_0200_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
    foreach (sizes[i])
      send_request(sizes[i], (i % 2) ? 32'hFFFF_FFFF : 32'h0, (i % 2) ? 8'hFF : 8'h00);
    send_request(64'd1 << 40, 32'hA5A5_5A5A, 8'h5A);
    send_request(64'd1 << 20, 32'h5A5A_A5A5, 8'hA5);
    idle_cycles(1);

    // sender pauses until every owed word has come
    while (board.owed_data.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    // random bursts with random gaps
    for (int n = 0; n < 250; n += burst) begin
      burst = $urandom_range(1, 8);
      for (int j = 0; j < burst; j++)
        send_request(pick_size(), $urandom, 8'($urandom));
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 150));
    end
    start <= 1'b0;

    while (board.owed_data.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
